>>> rtl/ibh_pkg.sv
`default_nettype none
package ibh_pkg;
    localparam int ID_BITS = 6;
    localparam int ID_COUNT = 64;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_NOP = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_FULL = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_ABSENT = 3'd3;
    localparam logic [2:0] ST_DUP = 3'd4;
endpackage
`default_nettype wire

>>> rtl/indexed_binary_heap.sv
`default_nettype none
// indexed binary heap priority queue of (key, id) entries
// command channel: raise start with op, item_key and item_id while busy is low;
// the command is taken on that edge and busy rises at once
// ops: insert, remove top, remove by id; order_mode picks min or max on top
// configuration: cfg_valid/cfg_ready write channel for order_mode, taken when idle
// one result per command, shown for one cycle with done high: top_key, top_id,
// entry_total, is_empty and status
// the receiver cannot stall: a result must be captured in its done cycle
// latency from the accepting edge to done, for 64 entries: 4 cycles for a
// command that changes nothing, up to 18 for an insert (2 cycles per level of
// sift up) and up to 29 for a removal (4 cycles per level of sift down)
// busy drops in the cycle after done, so one command takes 5 to 30 cycles
// one shared compare unit and the single port of each slot memory set the rate
// every memory step is read, compare, write over the sequencer states
// reset clears the entry count, the presence bits and order_mode; the slot
// memories need no clearing since only filled slots are read
module indexed_binary_heap
    import ibh_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [1:0]                 op,
    input  wire logic [31:0]                item_key,
    input  wire logic [ID_BITS-1:0]         item_id,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic                       cfg_data,
    output logic                            done,
    output logic [31:0]                     top_key,
    output logic [ID_BITS-1:0]              top_id,
    output logic [6:0]                      entry_total,
    output logic                            is_empty,
    output logic [2:0]                      status
);
    localparam int SB = $clog2(CAPACITY);
    localparam int CB = $clog2(CAPACITY + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_RDA   = 4'd2;
    localparam logic [3:0] S_RDB   = 4'd3;
    localparam logic [3:0] S_DECIDE = 4'd4;
    localparam logic [3:0] S_UPRD  = 4'd5;
    localparam logic [3:0] S_UPCMP = 4'd6;
    localparam logic [3:0] S_DNRDL = 4'd7;
    localparam logic [3:0] S_DNRDR = 4'd8;
    localparam logic [3:0] S_DNCMP = 4'd9;
    localparam logic [3:0] S_PLACE = 4'd10;
    localparam logic [3:0] S_TOP   = 4'd11;
    localparam logic [3:0] S_TOPW  = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;
    localparam logic [3:0] S_SLOTW = 4'd14;

    logic [KEY_BITS-1:0] key_mem [CAPACITY];
    logic [ID_BITS-1:0]  id_mem  [CAPACITY];
    logic [SB-1:0]       pos_mem [ID_COUNT];

    logic [3:0]          state_reg, state_next;
    logic [CB-1:0]       count_reg, count_next;
    logic [ID_COUNT-1:0] present_reg, present_next;
    logic                order_reg;
    logic [1:0]          op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;     // entry being placed
    logic [ID_BITS-1:0]  id_reg, id_next;
    logic [SB-1:0]       pos_reg, pos_next;     // hole slot
    logic [KEY_BITS-1:0] ka_reg, ka_next;       // operand a of compare
    logic [ID_BITS-1:0]  ia_reg, ia_next;
    logic [SB-1:0]       cpos_reg, cpos_next;   // candidate slot
    logic [2:0]          stat_reg, stat_next;
    logic [KEY_BITS-1:0] topk_reg, topk_next;
    logic [ID_BITS-1:0]  topi_reg, topi_next;

    // memory port control
    logic                mem_re;
    logic [SB-1:0]       mem_raddr;
    logic                mem_we;
    logic [SB-1:0]       mem_waddr;
    logic [KEY_BITS-1:0] mem_wkey;
    logic [ID_BITS-1:0]  mem_wid;
    logic [KEY_BITS-1:0] rd_key;
    logic [ID_BITS-1:0]  rd_id;
    logic                pm_re;
    logic [ID_BITS-1:0]  pm_raddr;
    logic [SB-1:0]       rd_pos;

    // shared compare unit: true when x must sit above y
    logic [KEY_BITS-1:0] cmp_x, cmp_y;
    logic                cmp_before;
    assign cmp_before = order_reg ? (cmp_x > cmp_y) : (cmp_x < cmp_y);

    logic [SB:0]   left_w;
    logic [SB:0]   right_w;
    logic [SB-1:0] parent_w;
    assign left_w   = {pos_reg, 1'b1};
    assign right_w  = left_w + (SB+1)'(1);
    assign parent_w = (pos_reg - SB'(1)) >> 1;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_waddr] <= mem_wkey;
            id_mem[mem_waddr]  <= mem_wid;
            pos_mem[mem_wid]   <= mem_waddr;
        end
        if (mem_re)
        begin
            rd_key <= key_mem[mem_raddr];
            rd_id  <= id_mem[mem_raddr];
        end
        if (pm_re)
        begin
            rd_pos <= pos_mem[pm_raddr];
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = ~busy;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        present_next = present_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        id_next      = id_reg;
        pos_next     = pos_reg;
        ka_next      = ka_reg;
        ia_next      = ia_reg;
        cpos_next    = cpos_reg;
        stat_next    = stat_reg;
        topk_next    = topk_reg;
        topi_next    = topi_reg;
        mem_re       = 1'b0;
        mem_raddr    = '0;
        mem_we       = 1'b0;
        mem_waddr    = pos_reg;
        mem_wkey     = key_reg;
        mem_wid      = id_reg;
        pm_re        = 1'b0;
        pm_raddr     = id_reg;
        cmp_x        = key_reg;
        cmp_y        = ka_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = op;
                    key_next  = KEY_BITS'(item_key);
                    id_next   = item_id;
                    stat_next = ST_OK;
                    pm_re     = 1'b1;
                    pm_raddr  = item_id;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_TOP;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (count_reg >= CB'(CAPACITY))
                            stat_next = ST_FULL;
                        else if (present_reg[id_reg])
                            stat_next = ST_DUP;
                        else
                        begin
                            present_next[id_reg] = 1'b1;
                            pos_next   = count_reg[SB-1:0];
                            count_next = count_reg + CB'(1);
                            state_next = (count_reg == '0) ? S_PLACE : S_UPRD;
                        end
                    end
                    OP_POP, OP_REMOVE:
                    begin
                        if (count_reg == '0)
                            stat_next = ST_EMPTY;
                        else if (op_reg == OP_REMOVE && (!present_reg[id_reg] ||
                                 CB'(rd_pos) >= count_reg))
                            stat_next = ST_ABSENT;
                        else
                        begin
                            pos_next   = (op_reg == OP_POP) ? '0 : rd_pos;
                            mem_re     = 1'b1;
                            mem_raddr  = (op_reg == OP_POP) ? '0 : rd_pos;
                            count_next = count_reg - CB'(1);
                            state_next = S_RDA;
                        end
                    end
                    default:
                    begin
                        state_next = S_TOP;
                    end
                endcase
            end
            S_RDA:
            begin
                // rd holds the removed entry; fetch last
                present_next[rd_id] = 1'b0;
                ka_next   = rd_key;
                mem_re    = 1'b1;
                mem_raddr = count_reg[SB-1:0];
                state_next = (CB'(pos_reg) < count_reg) ? S_RDB : S_TOP;
            end
            S_RDB:
            begin
                key_next   = rd_key;
                id_next    = rd_id;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmp_x = key_reg;
                cmp_y = ka_reg;
                state_next = cmp_before ? S_UPRD : S_DNRDL;
            end
            S_UPRD:
            begin
                if (pos_reg == '0)
                    state_next = S_PLACE;
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = parent_w;
                    cpos_next = parent_w;
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                cmp_x = rd_key;
                cmp_y = key_reg;
                if (cmp_before)
                    state_next = S_PLACE;
                else
                begin
                    mem_we    = 1'b1;
                    mem_wkey  = rd_key;
                    mem_wid   = rd_id;
                    pos_next  = cpos_reg;
                    state_next = S_UPRD;
                end
            end
            S_DNRDL:
            begin
                if (left_w >= (SB+1)'(count_reg))
                    state_next = S_PLACE;
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = left_w[SB-1:0];
                    cpos_next = left_w[SB-1:0];
                    state_next = S_DNRDR;
                end
            end
            S_DNRDR:
            begin
                ka_next = rd_key;
                ia_next = rd_id;
                if (right_w < (SB+1)'(count_reg))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = right_w[SB-1:0];
                    state_next = S_DNCMP;
                end
                else
                begin
                    state_next = S_SLOTW;
                end
            end
            S_DNCMP:
            begin
                // pick child: right unless left strictly before right
                cmp_x = ka_reg;
                cmp_y = rd_key;
                if (!cmp_before)
                begin
                    ka_next   = rd_key;
                    ia_next   = rd_id;
                    cpos_next = right_w[SB-1:0];
                end
                state_next = S_SLOTW;
            end
            S_SLOTW:
            begin
                cmp_x = key_reg;
                cmp_y = ka_reg;
                if (cmp_before)
                    state_next = S_PLACE;
                else
                begin
                    mem_we   = 1'b1;
                    mem_wkey = ka_reg;
                    mem_wid  = ia_reg;
                    pos_next = cpos_reg;
                    state_next = S_DNRDL;
                end
            end
            S_PLACE:
            begin
                mem_we     = 1'b1;
                state_next = S_TOP;
            end
            S_TOP:
            begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = S_TOPW;
            end
            S_TOPW:
            begin
                topk_next  = (count_reg == '0) ? '0 : rd_key;
                topi_next  = (count_reg == '0) ? '0 : rd_id;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            present_reg <= '0;
            order_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            present_reg <= present_next;
            if (cfg_valid && cfg_ready)
                order_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        id_reg   <= id_next;
        pos_reg  <= pos_next;
        ka_reg   <= ka_next;
        ia_reg   <= ia_next;
        cpos_reg <= cpos_next;
        stat_reg <= stat_next;
        topk_reg <= topk_next;
        topi_reg <= topi_next;
    end

    assign done        = (state_reg == S_DONE);
    assign top_key     = 32'(topk_reg);
    assign top_id      = topi_reg;
    assign entry_total = 7'(count_reg);
    assign is_empty    = (count_reg == '0);
    assign status      = stat_reg;
endmodule
`default_nettype wire
